// ----- hdl/cfrx_pkg.sv -----
// ----------------------------------------------------------------------------
// cfrx_pkg: shared types and constants of the CRC-checked frame receiver
// Beat types, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cfrx_pkg;

    // Longest frame accepted, in bytes (header, length and CRC included)
    localparam int unsigned MAX_FRAME_DEF = 256;
    // Shortest frame accepted: header, two length bytes, one spare byte, command, two CRC
    localparam int unsigned MIN_FRAME     = 7;

    // Reflected form of the CRC-16/KERMIT polynomial 0x1021
    localparam logic [15:0] CRC_POLY_REV  = 16'h8408;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST   = 16'd20000;
    localparam logic [7:0]  HEADER_RST    = 8'hFE;
    localparam logic [7:0]  SUCCESS_RST   = 8'h03;

    // Input commands
    localparam logic [1:0]  CMD_BYTE      = 2'd0;
    localparam logic [1:0]  CMD_TICK      = 2'd1;
    localparam logic [1:0]  CMD_START     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0]  CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0]  CFG_HEADER    = 2'd1;
    localparam logic [1:0]  CFG_SUCCESS   = 2'd2;

    // Result status codes
    localparam logic [2:0]  ST_SUCCESS    = 3'd0;
    localparam logic [2:0]  ST_CRC_BAD    = 3'd1;
    localparam logic [2:0]  ST_TOO_LONG   = 3'd2;
    localparam logic [2:0]  ST_TOO_SHORT  = 3'd3;
    localparam logic [2:0]  ST_OTHER_CMD  = 3'd4;
    localparam logic [2:0]  ST_TO_HUNT    = 3'd5;
    localparam logic [2:0]  ST_TO_LEN     = 3'd6;
    localparam logic [2:0]  ST_TO_DATA    = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HUNT,
        PH_LEN,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command_code;
        logic [15:0] crc_trailer;
        logic [15:0] crc_computed;
        logic [15:0] frame_length;
    } out_item_t;

endpackage : cfrx_pkg

`default_nettype wire

// ----- hdl/cfrx_crc.sv -----
// ----------------------------------------------------------------------------
// cfrx_crc: byte-wise CRC-16/KERMIT update
// Folds one byte into the running CRC, LSB first, reflected polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrx_crc
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_byte,
    output logic      [15:0] crc_out
);
    import cfrx_pkg::*;

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY_REV;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule : cfrx_crc

`default_nettype wire

// ----- hdl/cfrx_timer.sv -----
// ----------------------------------------------------------------------------
// cfrx_timer: listen window timer
// Counts millisecond ticks of the open window and flags the timeout tick.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrx_timer
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire cfrx_pkg::in_item_t item,
    input  wire logic              active,
    input  wire logic [15:0]       tick_limit,
    output logic                   timeout_hit
);
    import cfrx_pkg::*;

    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [15:0] elapsed_inc;
    logic        tick_ev;
    logic        start_ev;

    assign tick_ev     = fire && (item.cmd == CMD_TICK) && active;
    assign start_ev    = fire && (item.cmd == CMD_START);
    // saturate at full scale
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign timeout_hit = tick_ev && (elapsed_inc >= tick_limit);

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (start_ev)
        begin
            elapsed_next = 16'd0;
        end
        else if (tick_ev)
        begin
            elapsed_next = elapsed_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= 16'd0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

endmodule : cfrx_timer

`default_nettype wire

// ----- hdl/cfrx_parser.sv -----
// ----------------------------------------------------------------------------
// cfrx_parser: frame parser
// Hunts the header, takes the length, runs the CRC and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfrx_parser
#(
    parameter int unsigned MAX_FRAME = cfrx_pkg::MAX_FRAME_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire cfrx_pkg::in_item_t item,
    input  wire logic [7:0]         header_byte,
    input  wire logic [7:0]         success_code,
    input  wire logic               timeout_hit,
    output logic                    active,
    output logic                    res_valid,
    output cfrx_pkg::out_item_t     res
);
    import cfrx_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_FRAME + 1);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEN_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   idx_next;
    logic [LEN_W-1:0]   exp_reg;
    logic [LEN_W-1:0]   exp_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [7:0]         d0_reg;
    logic [7:0]         d0_next;
    logic [7:0]         d1_reg;
    logic [7:0]         d1_next;
    logic [7:0]         held_reg;
    logic [7:0]         held_next;

    logic [15:0]        crc_upd;
    logic               byte_ev;
    logic               start_ev;
    logic               is_header;
    logic               len_first;
    logic [15:0]        pair_value;
    logic               too_long;
    logic               too_short;
    logic [LEN_W:0]     idx_plus;
    logic               last_byte;
    logic [7:0]         held_now;
    logic               crc_ok;
    logic               success;

    // CRC over the byte two places back: the last two bytes never enter it
    cfrx_crc u_crc
    (
        .crc_in    (crc_reg),
        .data_byte (d1_reg),
        .crc_out   (crc_upd)
    );

    assign active     = (phase_reg != PH_IDLE);
    assign start_ev   = fire && (item.cmd == CMD_START);
    assign byte_ev    = fire && (item.cmd == CMD_BYTE) && active;
    assign is_header  = (item.rx_byte == header_byte);
    assign len_first  = (idx_reg == LEN_W'(1));
    assign pair_value = {d0_reg, item.rx_byte};
    assign too_long   = (pair_value > 16'(MAX_FRAME));
    assign too_short  = (pair_value < 16'(MIN_FRAME));
    assign idx_plus   = {1'b0, idx_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign last_byte  = (idx_plus >= {1'b0, exp_reg});
    assign held_now   = (idx_reg == LEN_W'(4)) ? item.rx_byte : held_reg;
    assign crc_ok     = (pair_value == crc_upd);
    assign success    = crc_ok && (held_now == success_code);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start_ev)
        begin
            phase_next = PH_HUNT;
        end
        else if (timeout_hit)
        begin
            phase_next = PH_IDLE;
        end
        else if (byte_ev)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_header)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (!len_first)
                    begin
                        phase_next = (too_long || too_short) ? PH_HUNT : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (last_byte)
                    begin
                        phase_next = success ? PH_IDLE : PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // frame datapath
    always_comb
    begin
        idx_next  = idx_reg;
        exp_next  = exp_reg;
        crc_next  = crc_reg;
        d0_next   = d0_reg;
        d1_next   = d1_reg;
        held_next = held_reg;
        if (start_ev || timeout_hit)
        begin
            idx_next  = '0;
            exp_next  = '0;
            crc_next  = 16'd0;
            d0_next   = 8'd0;
            d1_next   = 8'd0;
            held_next = 8'd0;
        end
        else if (byte_ev)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_header)
                    begin
                        idx_next  = LEN_W'(1);
                        exp_next  = '0;
                        crc_next  = 16'd0;
                        d0_next   = item.rx_byte;
                        d1_next   = 8'd0;
                        held_next = 8'd0;
                    end
                end
                PH_LEN:
                begin
                    if (len_first)
                    begin
                        d1_next  = d0_reg;
                        d0_next  = item.rx_byte;
                        idx_next = LEN_W'(2);
                    end
                    else if (too_long || too_short)
                    begin
                        idx_next  = '0;
                        exp_next  = '0;
                        crc_next  = 16'd0;
                        d0_next   = 8'd0;
                        d1_next   = 8'd0;
                        held_next = 8'd0;
                    end
                    else
                    begin
                        crc_next = crc_upd;
                        d1_next  = d0_reg;
                        d0_next  = item.rx_byte;
                        idx_next = LEN_W'(3);
                        exp_next = pair_value[LEN_W-1:0];
                    end
                end
                PH_DATA:
                begin
                    if (last_byte)
                    begin
                        idx_next  = '0;
                        exp_next  = '0;
                        crc_next  = 16'd0;
                        d0_next   = 8'd0;
                        d1_next   = 8'd0;
                        held_next = 8'd0;
                    end
                    else
                    begin
                        crc_next  = crc_upd;
                        d1_next   = d0_reg;
                        d0_next   = item.rx_byte;
                        idx_next  = idx_plus[LEN_W-1:0];
                        held_next = held_now;
                    end
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (timeout_hit)
        begin
            res_valid = 1'b1;
            case (phase_reg)
                PH_LEN:  res.status = ST_TO_LEN;
                PH_DATA: res.status = ST_TO_DATA;
                default: res.status = ST_TO_HUNT;
            endcase
        end
        else if (byte_ev && (phase_reg == PH_LEN) && !len_first && (too_long || too_short))
        begin
            res_valid        = 1'b1;
            res.status       = too_long ? ST_TOO_LONG : ST_TOO_SHORT;
            res.frame_length = pair_value;
        end
        else if (byte_ev && (phase_reg == PH_DATA) && last_byte)
        begin
            res_valid        = 1'b1;
            res.status       = !crc_ok ? ST_CRC_BAD : (success ? ST_SUCCESS : ST_OTHER_CMD);
            res.command_code = held_now;
            res.crc_trailer  = pair_value;
            res.crc_computed = crc_upd;
            res.frame_length = 16'(exp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            exp_reg   <= '0;
            crc_reg   <= 16'd0;
            d0_reg    <= 8'd0;
            d1_reg    <= 8'd0;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            exp_reg   <= exp_next;
            crc_reg   <= crc_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            held_reg  <= held_next;
        end
    end

`ifndef SYNTHESIS
    a_data_idx_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (idx_reg < exp_reg))
        else $error("byte index ran past the frame length");

    a_data_len_bounds : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |->
            ((exp_reg >= LEN_W'(MIN_FRAME)) && (exp_reg <= LEN_W'(MAX_FRAME))))
        else $error("accepted frame length out of bounds");
`endif

endmodule : cfrx_parser

`default_nettype wire

// ----- hdl/crc_checked_frame_receiver.sv -----
// Latency: a result beat is offered on the cycle after the input beat that causes it.
// Throughput: one input beat per cycle; a waiting result stalls input only while
// out_ready is low, the output register being the only stage on the result path.
// Reset: rst_n clears the window to idle, the timer to zero and the registers to
// timeout 20000 ticks, header 0xFE, success code 0x03; no clearing pass is needed.
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver: length-prefixed frame receiver with CRC-16 check
// Opens a listen window on a start beat, hunts for the header byte, reads a
// big-endian total length, checks CRC-16/KERMIT over the frame body and
// reports one status beat per finished, discarded or timed-out frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_receiver
#(
    parameter int unsigned MAX_FRAME = cfrx_pkg::MAX_FRAME_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input beats
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cfrx_pkg::in_item_t  in_data,
    // result beats
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cfrx_pkg::out_item_t      out_data,
    // register writes
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import cfrx_pkg::*;

    logic        in_fire;
    logic        cfg_fire;

    logic [15:0] timeout_reg;
    logic [7:0]  header_reg;
    logic [7:0]  success_reg;

    logic        active;
    logic        timeout_hit;
    logic        res_valid;
    out_item_t   res;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_data_reg;

    // Take a new beat whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Registers: writes to an unknown index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            header_reg  <= HEADER_RST;
            success_reg <= SUCCESS_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_HEADER:  header_reg  <= cfg_data[7:0];
                CFG_SUCCESS: success_reg <= cfg_data[7:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    // Window timer: counts ticks while listening, flags the expiring tick
    cfrx_timer u_timer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .item        (in_data),
        .active      (active),
        .tick_limit  (timeout_reg),
        .timeout_hit (timeout_hit)
    );

    // Frame parser: all per-beat work, one pass, result ready in the same cycle
    cfrx_parser
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .item         (in_data),
        .header_byte  (header_reg),
        .success_code (success_reg),
        .timeout_hit  (timeout_hit),
        .active       (active),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Result register: load on every accepted beat, clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold unless a new result arrives
    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_result_has_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result beat appeared without an accepted input beat");

    a_start_silent : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.cmd == CMD_START)) |=> !out_valid)
        else $error("start beat produced a result");

    a_timeout_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_data.status == ST_TO_HUNT) || (out_data.status == ST_TO_LEN)
            || (out_data.status == ST_TO_DATA)))
        |-> ((out_data.command_code == 8'd0) && (out_data.crc_trailer == 16'd0)
            && (out_data.crc_computed == 16'd0) && (out_data.frame_length == 16'd0)))
        else $error("timeout result carries frame fields");

    a_length_reject_bounds : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_TOO_LONG))
        |-> (out_data.frame_length > 16'(MAX_FRAME)))
        else $error("too-long status with a length in range");
`endif

endmodule : crc_checked_frame_receiver

`default_nettype wire

// ----- sim/tb_crc_checked_frame_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc_checked_frame_receiver: self-checking bench for the frame receiver
// Feeds byte, tick and start beats through a randomly stalled handshake and
// mirrors the receiver (hunt, length, body, CRC-16/KERMIT check, window
// timer) beat by beat. Every status beat is compared field by field with the
// oldest verdict waiting.
// ----------------------------------------------------------------------------

module tb_crc_checked_frame_receiver;

    import cfrx_pkg::*;

    // The package names three commands; the fourth code must be ignored
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned IDLE_PCT      = 27;
    localparam int unsigned HOLD_CYCLES   = 300;
    // The result path is registered; let the block settle before calling it idle
    localparam int unsigned SETTLE_CYCLES = 4;
    // Watchdog bound for a correct run with both sides idling and the long
    // hold-off, with a wide margin
    localparam int unsigned LIMIT_CYCLES  = 100000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_TIMEOUT;
    logic [15:0] cfg_data  = 16'h0000;

    // Beats waiting to be offered, and verdicts waiting for their status beat
    in_item_t    pending_beats[$];
    out_item_t   due_reports[$];
    out_item_t   oldest;
    int unsigned mismatch_count = 0;

    // Pacing controls, each with a single writer
    bit          no_idle = 1'b0;
    bit          hold_go = 1'b0;
    logic        rx_hold = 1'b0;

    // Shadow of the registers, updated when a write is accepted
    logic [15:0] cfg_timeout = TIMEOUT_RST;
    logic [7:0]  cfg_header  = HEADER_RST;
    logic [7:0]  cfg_success = SUCCESS_RST;

    // Mirror of the receiver state
    phase_t      rx_phase   = PH_IDLE;
    logic [15:0] tick_count = 16'h0000;
    logic [8:0]  byte_pos   = 9'd0;
    logic [8:0]  want_len   = 9'd0;
    logic [15:0] crc_acc    = 16'h0000;
    logic [7:0]  lag0       = 8'h00;
    logic [7:0]  lag1       = 8'h00;
    logic [7:0]  cmd_byte   = 8'h00;

    crc_checked_frame_receiver u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // CRC and receiver mirror
    // ------------------------------------------------------------------------

    // One byte of CRC-16/KERMIT: reflected, init zero, no final xor
    function automatic logic [15:0] kermit_step(input logic [15:0] crc,
                                                input logic [7:0] octet);
        logic [15:0] acc;
        acc = crc ^ {8'h00, octet};
        for (int k = 0; k < 8; k++)
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REV) : (acc >> 1);
        return acc;
    endfunction

    function automatic void restart_hunt();
        rx_phase  = PH_HUNT;
        byte_pos  = 9'd0;
        want_len  = 9'd0;
        crc_acc   = 16'h0000;
        lag0      = 8'h00;
        lag1      = 8'h00;
        cmd_byte  = 8'h00;
    endfunction

    // The CRC trails the byte stream by two, so the CRC bytes never enter it
    function automatic void shift_byte(input logic [7:0] octet);
        if (byte_pos >= 2)
            crc_acc = kermit_step(crc_acc, lag1);
        lag1 = lag0;
        lag0 = octet;
    endfunction

    // Advance the mirror by one accepted beat; queue the verdict it causes
    task automatic follow_receiver(input in_item_t beat);
        out_item_t   res;
        logic [15:0] len;
        res = '0;
        if (beat.cmd == CMD_START)
        begin
            tick_count = 16'h0000;
            restart_hunt();
            return;
        end
        if (rx_phase == PH_IDLE || beat.cmd == CMD_UNUSED)
            return;

        if (beat.cmd == CMD_TICK)
        begin
            if (tick_count != 16'hFFFF)
                tick_count = tick_count + 16'd1;
            if (tick_count >= cfg_timeout)
            begin
                res.status = (rx_phase == PH_LEN)  ? ST_TO_LEN :
                             (rx_phase == PH_DATA) ? ST_TO_DATA : ST_TO_HUNT;
                due_reports.push_back(res);
                restart_hunt();
                rx_phase = PH_IDLE;
            end
            return;
        end

        case (rx_phase)
            PH_HUNT:
            begin
                if (beat.rx_byte == cfg_header)
                begin
                    restart_hunt();
                    rx_phase = PH_LEN;
                    shift_byte(beat.rx_byte);
                    byte_pos = 9'd1;
                end
            end
            PH_LEN:
            begin
                if (byte_pos == 9'd1)
                begin
                    shift_byte(beat.rx_byte);
                    byte_pos = 9'd2;
                end
                else
                begin
                    len = {lag0, beat.rx_byte};
                    shift_byte(beat.rx_byte);
                    byte_pos = 9'd3;
                    if (len > MAX_FRAME_DEF || len < MIN_FRAME)
                    begin
                        res.status       = (len > MAX_FRAME_DEF) ? ST_TOO_LONG : ST_TOO_SHORT;
                        res.frame_length = len;
                        due_reports.push_back(res);
                        restart_hunt();
                    end
                    else
                    begin
                        want_len = len[8:0];
                        rx_phase = PH_DATA;
                    end
                end
            end
            default:
            begin
                if (byte_pos == 9'd4)
                    cmd_byte = beat.rx_byte;
                if (byte_pos + 1 >= want_len)
                begin
                    res.crc_trailer = {lag0, beat.rx_byte};
                    shift_byte(beat.rx_byte);
                    res.command_code = cmd_byte;
                    res.crc_computed = crc_acc;
                    res.frame_length = {7'd0, want_len};
                    if (res.crc_trailer != crc_acc)
                        res.status = ST_CRC_BAD;
                    else if (cmd_byte == cfg_success)
                        res.status = ST_SUCCESS;
                    else
                        res.status = ST_OTHER_CMD;
                    due_reports.push_back(res);
                    restart_hunt();
                    if (res.status == ST_SUCCESS)
                        rx_phase = PH_IDLE;
                end
                else
                begin
                    shift_byte(beat.rx_byte);
                    byte_pos = byte_pos + 9'd1;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Input beat driver: pop the next beat when the slot is free, idle at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            // Mirror the beat the block takes at this edge
            if (in_valid && in_ready)
                follow_receiver(in_data);
            // Hold valid and payload until the beat is taken
            if (!in_valid || in_ready)
            begin
                if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Status beat monitor: compare each taken beat with the oldest verdict
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                    flag_mismatch($sformatf("status beat 0x%0h with no verdict waiting",
                                            out_data.status));
                else
                begin
                    oldest = due_reports.pop_front();
                    check_field("status", 16'(out_data.status), 16'(oldest.status));
                    check_field("command_code", 16'(out_data.command_code),
                                16'(oldest.command_code));
                    check_field("crc_trailer",  out_data.crc_trailer,  oldest.crc_trailer);
                    check_field("crc_computed", out_data.crc_computed, oldest.crc_computed);
                    check_field("frame_length", out_data.frame_length, oldest.frame_length);
                end
            end
            out_ready <= !rx_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long receiver hold-off, timed here so the sender keeps offering beats
    // and the block has to stall its input behind a full result register
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_beat(input logic [1:0] cmd, input logic [7:0] octet);
        pending_beats.push_back(in_item_t'({cmd, octet}));
    endtask

    // Header plus length field only: enough to hit the length checks
    task automatic queue_length(input logic [15:0] len);
        queue_beat(CMD_BYTE, cfg_header);
        queue_beat(CMD_BYTE, len[15:8]);
        queue_beat(CMD_BYTE, len[7:0]);
    endtask

    // Whole frame of len bytes with the command at offset 4; spoil flips a
    // single bit of the CRC trailer
    task automatic queue_frame(input logic [15:0] len, input logic [7:0] code,
                               input bit spoil);
        logic [15:0] crc;
        logic [7:0]  octet;
        crc = 16'h0000;
        for (int unsigned pos = 0; pos < len - 2; pos++)
        begin
            case (pos)
                0:       octet = cfg_header;
                1:       octet = len[15:8];
                2:       octet = len[7:0];
                4:       octet = code;
                default: octet = 8'($urandom_range(255));
            endcase
            crc = kermit_step(crc, octet);
            queue_beat(CMD_BYTE, octet);
        end
        if (spoil)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        queue_beat(CMD_BYTE, crc[15:8]);
        queue_beat(CMD_BYTE, crc[7:0]);
    endtask

    // Mostly short frames; the odd medium one and, rarely, the longest allowed
    function automatic logic [15:0] pick_frame_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return 16'(MAX_FRAME_DEF);
        else if (r < 15)
            return 16'($urandom_range(64, 21));
        return 16'($urandom_range(20, MIN_FRAME));
    endfunction

    task automatic queue_random_scenario(input bit tick_bursts);
        int unsigned pick;
        int unsigned n;
        logic [7:0]  code;
        pick = $urandom_range(99);
        // Occasionally reopen the window first
        if ($urandom_range(4) == 0)
            queue_beat(CMD_START, 8'($urandom_range(255)));
        if (pick < 70)
        begin
            // Well-formed frame (spoilt CRC in about one case in five)
            code = ($urandom_range(3) == 0) ? cfg_success : 8'($urandom_range(255));
            queue_frame(pick_frame_len(), code, pick >= 55);
            // A success closes the window; reopen it so the stream is not ignored
            if (code == cfg_success && pick < 55)
                queue_beat(CMD_START, 8'($urandom_range(255)));
        end
        else if (pick < 80)
        begin
            if ($urandom_range(1) == 0)
                queue_length(16'($urandom_range(65535, MAX_FRAME_DEF + 1)));
            else
                queue_length(16'($urandom_range(MIN_FRAME - 1, 0)));
        end
        else if (pick < 90)
        begin
            // Line noise of every command code, then maybe a fresh window
            n = $urandom_range(6, 1);
            repeat (n) queue_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
            if ($urandom_range(1) == 0)
                queue_beat(CMD_START, 8'($urandom_range(255)));
        end
        else if (tick_bursts)
        begin
            n = $urandom_range(8, 1);
            repeat (n) queue_beat(CMD_TICK, 8'($urandom_range(255)));
            queue_beat(CMD_START, 8'($urandom_range(255)));
        end
        else
        begin
            // Abandon a frame part way through with a new window
            queue_length(16'($urandom_range(40, MIN_FRAME)));
            n = $urandom_range(5);
            repeat (n) queue_beat(CMD_BYTE, 8'($urandom_range(255)));
            queue_beat(CMD_START, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_phase(input int unsigned beats, input bit tick_bursts);
        queue_beat(CMD_START, 8'($urandom_range(255)));
        while (pending_beats.size() < beats)
            queue_random_scenario(tick_bursts);
    endtask

    // Register write on its own channel; only called with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIMEOUT: cfg_timeout = value;
            CFG_HEADER:  cfg_header  = value[7:0];
            CFG_SUCCESS: cfg_success = value[7:0];
            default:     ;
        endcase
        @(negedge clk);
    endtask

    // Stop sending until every beat is taken and every verdict has arrived,
    // then let the block settle; sampled on the falling edge to stay clear of
    // the updates made at the rising one
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || due_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, on the reset register values. Drop bytes, ticks and the
        // unused code while idle; then open a window and walk every verdict but the timeouts.
        queue_beat(CMD_BYTE, HEADER_RST);
        queue_beat(CMD_TICK, 8'h00);
        queue_beat(CMD_UNUSED, 8'hAA);
        queue_beat(CMD_START, 8'h5A);
        queue_beat(CMD_UNUSED, HEADER_RST);
        queue_beat(CMD_BYTE, 8'h12);
        queue_frame(16'd7, 8'h55, 1'b0);
        queue_frame(16'd7, SUCCESS_RST, 1'b1);
        queue_length(16'(MAX_FRAME_DEF + 1));
        queue_length(16'hFFFF);
        queue_length(16'(MIN_FRAME - 1));
        queue_length(16'd0);
        queue_frame(16'(MAX_FRAME_DEF), 8'h00, 1'b0);
        // Restart the window in the middle of a frame body
        queue_length(16'd12);
        queue_beat(CMD_BYTE, 8'hFF);
        queue_beat(CMD_BYTE, 8'h00);
        queue_beat(CMD_START, 8'h00);
        queue_frame(16'd8, SUCCESS_RST, 1'b0);
        // Window closed by the success: this frame must vanish
        queue_frame(16'd7, SUCCESS_RST, 1'b0);
        wait_drained();

        // Timeout in each phase, on the shortest windows
        write_reg(CFG_TIMEOUT, 16'd1);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_TICK, 8'h00);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_BYTE, cfg_header);
        queue_beat(CMD_TICK, 8'h00);
        wait_drained();
        write_reg(CFG_TIMEOUT, 16'd2);
        queue_beat(CMD_START, 8'h00);
        queue_beat(CMD_TICK, 8'h00);
        queue_length(16'd10);
        queue_beat(CMD_TICK, 8'h00);
        queue_beat(CMD_TICK, 8'h00);
        wait_drained();

        // Widest window: a short run of ticks must not expire it
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        queue_beat(CMD_START, 8'h00);
        repeat (20) queue_beat(CMD_TICK, 8'($urandom_range(255)));
        wait_drained();

        // Random traffic, header and success code at their extremes
        write_reg(CFG_HEADER, 16'h0000);
        write_reg(CFG_SUCCESS, 16'h00FF);
        write_reg(CFG_TIMEOUT, TIMEOUT_RST);
        run_random_phase(120, 1'b0);
        wait_drained();
        // Same settings again after a full pause of the sender
        run_random_phase(80, 1'b0);
        wait_drained();

        write_reg(CFG_HEADER, 16'h00FF);
        write_reg(CFG_SUCCESS, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'($urandom_range(6, 1)));
        run_random_phase(120, 1'b1);
        wait_drained();

        write_reg(CFG_HEADER, 16'($urandom_range(255)));
        write_reg(CFG_SUCCESS, 16'($urandom_range(255)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(40, 8)));
        run_random_phase(120, 1'b1);
        wait_drained();

        // Back-pressure: a burst of rejected lengths against a stalled receiver
        hold_go = 1'b1;
        queue_beat(CMD_START, 8'h00);
        repeat (40) queue_length(16'($urandom_range(MIN_FRAME - 1, 0)));
        wait_drained();

        // Long stretch with both sides running flat out
        write_reg(CFG_TIMEOUT, TIMEOUT_RST);
        no_idle = 1'b1;
        run_random_phase(120, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        if (mismatch_count == 0 && due_reports.size() == 0)
            $display("tb_crc_checked_frame_receiver: PASS");
        else
            $display("tb_crc_checked_frame_receiver: FAIL");
        $finish;
    end

    // Watchdog: give up if the run hangs
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_crc_checked_frame_receiver: FAIL");
        $finish;
    end

endmodule
